FILE: rtl/hbc_pkg.sv
// ============================================================================
// hbc_pkg
// Shared types and constants for the hysteresis backfill classifier.
// ============================================================================
package hbc_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;
    localparam int THR_BITS        = 16;
    localparam int HELD_COUNT_BITS = 16;
    localparam int CFG_ADDR_BITS   = 3;
    localparam int CFG_DATA_BITS   = 16;

    // Band of a sample against the two thresholds
    typedef enum logic [1:0] {
        BAND_LOW  = 2'd0,
        BAND_MID  = 2'd1,
        BAND_HIGH = 2'd2
    } band_t;

    // Configuration register map
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        CFG_LOW_THR    = 3'd0,
        CFG_HIGH_THR   = 3'd1,
        CFG_INVERT     = 3'd2,
        CFG_QUICK_RISE = 3'd3,
        CFG_QUICK_FALL = 3'd4
    } cfg_reg_t;

    // One run-length coded result
    typedef struct packed {
        logic [HELD_COUNT_BITS-1:0] held_count;
        logic                       held_level;
        logic                       sample_present;
        logic                       sample_level;
        logic                       signal_done;
        logic                       overflow;
    } res_t;

endpackage

FILE: rtl/hbc_if.sv
// ============================================================================
// hbc_if
// Valid/ready channels of the classifier: samples, results, configuration.
// ============================================================================

interface hbc_in_if
    import hbc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          end_mark;

    modport source (output valid, output sample, output end_mark, input ready);
    modport sink   (input valid, input sample, input end_mark, output ready);
endinterface

interface hbc_out_if
    import hbc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [HELD_COUNT_BITS-1:0] held_count;
    logic                       held_level;
    logic                       sample_present;
    logic                       sample_level;
    logic                       signal_done;
    logic                       overflow;

    modport source (output valid, output held_count, output held_level,
                    output sample_present, output sample_level,
                    output signal_done, output overflow, input ready);
    modport sink   (input valid, input held_count, input held_level,
                    input sample_present, input sample_level,
                    input signal_done, input overflow, output ready);
endinterface

interface hbc_cfg_if
    import hbc_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [CFG_ADDR_BITS-1:0] addr;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output addr, output data, input ready);
    modport sink   (input valid, input addr, input data, output ready);
endinterface

FILE: rtl/hysteresis_backfill_classifier.sv
// ============================================================================
// hysteresis_backfill_classifier
// Three-band hysteresis classifier that holds middle-band runs and decides
// their level when the run ends, emitting run-length coded results.
// ============================================================================
// Latency: a result is valid in the cycle after the sample transfer that
// causes it. Throughput: one sample per cycle; the result register is the
// only storage between the sides, so a sample is refused only while that
// register is full and not being taken. Middle-band samples without an end
// mark produce no result. Reset (rst_n low, asynchronous) clears the run
// state and the result valid, and loads the threshold registers with low 0,
// high 1, and all mode bits 0.
// ============================================================================
module hysteresis_backfill_classifier
    import hbc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
    input  logic     clk,
    input  logic     rst_n,
    hbc_in_if.sink   smp,
    hbc_out_if.source res,
    hbc_cfg_if.sink  cfg
);

    // Compare width covers both the sample and the threshold registers
    localparam int CMP_BITS = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [THR_BITS-1:0] low_thr_reg;
    logic signed [THR_BITS-1:0] high_thr_reg;
    logic                       invert_reg;
    logic                       quick_rise_reg;
    logic                       quick_fall_reg;

    // Always ready: no write is ever stalled
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg    <= '0;
            high_thr_reg   <= THR_BITS'(1);
            invert_reg     <= 1'b0;
            quick_rise_reg <= 1'b0;
            quick_fall_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.addr)
                CFG_LOW_THR:    low_thr_reg    <= cfg.data[THR_BITS-1:0];
                CFG_HIGH_THR:   high_thr_reg   <= cfg.data[THR_BITS-1:0];
                CFG_INVERT:     invert_reg     <= cfg.data[0];
                CFG_QUICK_RISE: quick_rise_reg <= cfg.data[0];
                CFG_QUICK_FALL: quick_fall_reg <= cfg.data[0];
                default:        ; // unmapped index: drop the write
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Run state
    // ------------------------------------------------------------------
    band_t                 band_reg,   band_next;
    logic                  origin_reg, origin_next;   // run began from high band
    logic [COUNT_BITS-1:0] run_reg,    run_next;
    logic                  sat_reg,    sat_next;

    // Result register (the skid between input and output sides)
    logic out_valid_reg, out_valid_next;
    res_t res_reg;
    res_t res_next;

    logic                       in_xfer;
    logic                       emit;
    band_t                      band;
    logic signed [CMP_BITS-1:0] s_ext;
    logic signed [CMP_BITS-1:0] lo_ext;
    logic signed [CMP_BITS-1:0] hi_ext;
    logic [COUNT_BITS-1:0]      held_val;
    logic                       held_lvl;
    logic [COUNT_BITS+HELD_COUNT_BITS-1:0] held_wide;

    // Take a new sample whenever the result register is free or draining
    assign smp.ready = !out_valid_reg || res.ready;
    assign in_xfer   = smp.valid && smp.ready;

    // Sign-extend everything to a common compare width
    assign s_ext  = CMP_BITS'(smp.sample);
    assign lo_ext = CMP_BITS'(low_thr_reg);
    assign hi_ext = CMP_BITS'(high_thr_reg);

    always_comb
    begin
        priority if (s_ext > hi_ext)
            band = BAND_HIGH;
        else if (s_ext > lo_ext)
            band = BAND_MID;
        else
            band = BAND_LOW;
    end

    // Zero-extend the run count before cutting it to the result field width
    assign held_wide = {{HELD_COUNT_BITS{1'b0}}, held_val};

    always_comb
    begin
        band_next   = band_reg;
        origin_next = origin_reg;
        run_next    = run_reg;
        sat_next    = sat_reg;
        emit        = 1'b0;
        held_val    = '0;
        held_lvl    = 1'b0;
        res_next    = '0;

        if (band == BAND_MID)
        begin
            // Open a new run, or extend the current one up to saturation
            if (band_reg != BAND_MID)
            begin
                origin_next = (band_reg == BAND_HIGH);
                run_next    = COUNT_BITS'(1);
            end
            else if (&run_reg)
            begin
                sat_next = 1'b1;
            end
            else
            begin
                run_next = run_reg + COUNT_BITS'(1);
            end
            band_next = BAND_MID;

            // End mark flushes the run by its origin alone
            emit     = smp.end_mark;
            held_val = run_next;
            held_lvl = origin_next ^ invert_reg;
            res_next.sample_present = 1'b0;
            res_next.sample_level   = 1'b0;
            res_next.overflow       = sat_next;
        end
        else
        begin
            emit = 1'b1;
            if (band_reg == BAND_MID)
            begin
                held_val = run_reg;
                if (band == BAND_LOW)
                    held_lvl = (origin_reg && !quick_fall_reg) ^ invert_reg;
                else
                    held_lvl = (origin_reg || quick_rise_reg) ^ invert_reg;
            end
            res_next.sample_present = 1'b1;
            res_next.sample_level   = (band == BAND_HIGH) ^ invert_reg;
            res_next.overflow       = sat_reg;
            band_next = band;
            run_next  = '0;
            sat_next  = 1'b0;
        end

        res_next.held_count  = held_wide[HELD_COUNT_BITS-1:0];
        res_next.held_level  = (held_val != '0) ? held_lvl : 1'b0;
        res_next.signal_done = smp.end_mark;

        // End of signal: return the run state to its reset values
        if (smp.end_mark)
        begin
            band_next   = BAND_LOW;
            origin_next = 1'b0;
            run_next    = '0;
            sat_next    = 1'b0;
        end
    end

    // Load on a producing transfer, drop once taken, else hold
    always_comb
    begin
        priority if (in_xfer && emit)
            out_valid_next = 1'b1;
        else if (res.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            band_reg      <= BAND_LOW;
            origin_reg    <= 1'b0;
            run_reg       <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (in_xfer)
            begin
                band_reg   <= band_next;
                origin_reg <= origin_next;
                run_reg    <= run_next;
                sat_reg    <= sat_next;
            end
        end
    end

    // Payload needs no reset; advance it only on a producing transfer
    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
            res_reg <= res_next;
    end

    assign res.valid          = out_valid_reg;
    assign res.held_count     = res_reg.held_count;
    assign res.held_level     = res_reg.held_level;
    assign res.sample_present = res_reg.sample_present;
    assign res.sample_level   = res_reg.sample_level;
    assign res.signal_done    = res_reg.signal_done;
    assign res.overflow       = res_reg.overflow;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A full, stalled result register must hold off new samples
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res.ready) |-> !smp.ready)
        else $error("sample accepted while result register stalled");

    // Without its own sample, a result can only be the end-of-signal flush
    a_flush_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.sample_present) |-> res.signal_done)
        else $error("result without sample that does not close the signal");

    // An absent sample carries no level
    a_absent_level: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.sample_present) |-> !res.sample_level)
        else $error("sample level set on a result without sample");

    // An end mark leaves the run state at its reset values
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && smp.end_mark) |=>
            (band_reg == BAND_LOW && run_reg == '0 && !sat_reg && !origin_reg))
        else $error("run state not cleared after end of signal");

endmodule

FILE: tb/band_result_checker.sv
// ----------------------------------------------------------------------------
// band_result_checker
// Watches the sample, result and register channels of the hysteresis
// classifier. It predicts every result and compares each one, field by
// field, with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module band_result_checker
    import hbc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    hbc_in_if    smp,
    hbc_out_if   res,
    hbc_cfg_if   cfg,
    output int   mismatches,
    output int   results_checked,
    output int   waiting_results
);
    timeunit 1ns;
    timeprecision 1ps;

    // Cap on printed mismatch lines; counting goes on past it
    localparam int PRINT_CAP = 40;

    logic signed [THR_BITS-1:0] low_thr;
    logic signed [THR_BITS-1:0] high_thr;
    bit                         invert;
    bit                         quick_rise;
    bit                         quick_fall;

    band_t                      last_band;
    bit                         origin_high;
    logic [COUNT_BITS-1:0]      run_len;
    bit                         run_saturated;

    res_t                       band_results_q[$];
    res_t                       seen_res;
    res_t                       want_res;
    res_t                       new_res;

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] result %0d: %s got %0d, want %0d",
                     $realtime, results_checked, what, got, want);
        mismatches++;
    endtask

    function automatic void clear_run();
        last_band     = BAND_LOW;
        origin_high   = 1'b0;
        run_len       = '0;
        run_saturated = 1'b0;
    endfunction

    // Advance the band state by one sample; returns 1 when a result is due
    function automatic bit classify_sample(input logic signed [SAMPLE_BITS_DEF-1:0] s,
                                           input bit last, output res_t r);
        band_t band;
        bit    act;
        bit    inact;
        r     = '0;
        act   = !invert;
        inact = invert;
        if (s > high_thr)
            band = BAND_HIGH;
        else if (s > low_thr)
            band = BAND_MID;
        else
            band = BAND_LOW;

        if (band == BAND_MID)
        begin
            if (last_band != BAND_MID)
            begin
                origin_high = (last_band == BAND_HIGH);
                run_len     = COUNT_BITS'(1);
            end
            else if (run_len == '1)
                run_saturated = 1'b1;
            else
                run_len++;
            last_band = BAND_MID;
            if (!last)
                return 1'b0;
            // closing inside a run: origin decides, quick modes do not
            r.held_count = HELD_COUNT_BITS'(run_len);
            r.held_level = origin_high ? act : inact;
        end
        else
        begin
            if (last_band == BAND_MID && run_len != 0)
            begin
                r.held_count = HELD_COUNT_BITS'(run_len);
                if (band == BAND_LOW)
                    r.held_level = (origin_high && !quick_fall) ? act : inact;
                else
                    r.held_level = (origin_high || quick_rise) ? act : inact;
            end
            r.sample_present = 1'b1;
            r.sample_level   = (band == BAND_HIGH) ? act : inact;
            last_band        = band;
            run_len          = '0;
        end
        r.signal_done = last;
        r.overflow    = run_saturated;
        if (band != BAND_MID)
            run_saturated = 1'b0;
        if (last)
            clear_run();
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr         = '0;
            high_thr        = THR_BITS'(1);
            invert          = 1'b0;
            quick_rise      = 1'b0;
            quick_fall      = 1'b0;
            clear_run();
            band_results_q.delete();
            mismatches      = 0;
            results_checked = 0;
            waiting_results = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.addr)
                    CFG_LOW_THR:    low_thr    = cfg.data[THR_BITS-1:0];
                    CFG_HIGH_THR:   high_thr   = cfg.data[THR_BITS-1:0];
                    CFG_INVERT:     invert     = cfg.data[0];
                    CFG_QUICK_RISE: quick_rise = cfg.data[0];
                    CFG_QUICK_FALL: quick_fall = cfg.data[0];
                    default: ;
                endcase
            end

            // a result never leaves in the cycle of its own sample, so compare first
            if (res.valid && res.ready)
            begin
                seen_res.held_count     = res.held_count;
                seen_res.held_level     = res.held_level;
                seen_res.sample_present = res.sample_present;
                seen_res.sample_level   = res.sample_level;
                seen_res.signal_done    = res.signal_done;
                seen_res.overflow       = res.overflow;
                if (band_results_q.size() == 0)
                    report_mismatch("result with nothing expected", 1, 0);
                else
                begin
                    want_res = band_results_q.pop_front();
                    if (seen_res.held_count !== want_res.held_count)
                        report_mismatch("held_count", seen_res.held_count,
                                        want_res.held_count);
                    if (seen_res.held_level !== want_res.held_level)
                        report_mismatch("held_level", seen_res.held_level,
                                        want_res.held_level);
                    if (seen_res.sample_present !== want_res.sample_present)
                        report_mismatch("sample_present", seen_res.sample_present,
                                        want_res.sample_present);
                    if (seen_res.sample_level !== want_res.sample_level)
                        report_mismatch("sample_level", seen_res.sample_level,
                                        want_res.sample_level);
                    if (seen_res.signal_done !== want_res.signal_done)
                        report_mismatch("signal_done", seen_res.signal_done,
                                        want_res.signal_done);
                    if (seen_res.overflow !== want_res.overflow)
                        report_mismatch("overflow", seen_res.overflow,
                                        want_res.overflow);
                end
                results_checked++;
            end

            if (smp.valid && smp.ready)
            begin
                if (classify_sample(smp.sample, smp.end_mark, new_res))
                    band_results_q.push_back(new_res);
            end
            waiting_results = band_results_q.size();
        end
    end

endmodule

FILE: tb/hysteresis_backfill_classifier_test.sv
// ----------------------------------------------------------------------------
// hysteresis_backfill_classifier_test
// Drives samples and register writes into the hysteresis classifier with
// random gaps and back-pressure, and gives the verdict from the checker's
// mismatch count.
// ----------------------------------------------------------------------------
module hysteresis_backfill_classifier_test;
    timeunit 1ns;
    timeprecision 1ps;
    import hbc_pkg::*;

    localparam int IDLE_PERCENT  = 38;
    localparam int QUIET_LIMIT   = 2000;   // cycles with no transfer before giving up
    localparam int SETTLE_CYCLES = 4;      // the result is registered; allow a margin
    localparam int PHASE_ITEMS   = 150;
    localparam int PHASE_COUNT   = 8;

    logic clk;
    logic rst_n;
    bit   calm;            // 1: neither side idles
    int   lo_sel;          // thresholds currently loaded, for aimed samples
    int   hi_sel;
    int   samples_sent;
    int   cfg_writes;
    int   settings_used;
    int   quiet_cycles;
    int   mismatches;
    int   results_checked;
    int   waiting_results;
    int   phase;
    int   lo;
    int   hi;

    hbc_in_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) smp_ch ();
    hbc_out_if res_ch ();
    hbc_cfg_if cfg_ch ();

    hysteresis_backfill_classifier #(
        .SAMPLE_BITS (SAMPLE_BITS_DEF),
        .COUNT_BITS  (COUNT_BITS_DEF)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .smp   (smp_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    band_result_checker #(
        .COUNT_BITS (COUNT_BITS_DEF)
    ) result_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .smp             (smp_ch),
        .res             (res_ch),
        .cfg             (cfg_ch),
        .mismatches      (mismatches),
        .results_checked (results_checked),
        .waiting_results (waiting_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Roll for an idle cycle on either side; never idle during a calm stretch
    function automatic bit idle_roll();
        return !calm && ($urandom_range(99) < IDLE_PERCENT);
    endfunction

    // Pick a sample that lands in the wanted band under the loaded thresholds.
    // Fall back to a raw random value when that band is empty.
    function automatic logic signed [15:0] pick_sample(band_t b);
        int floor_top;
        bit at_border;
        floor_top = (lo_sel < hi_sel) ? lo_sel : hi_sel;
        at_border = ($urandom_range(99) < 15);
        case (b)
            BAND_LOW:
                return at_border ? 16'(floor_top)
                                 : 16'(floor_top - int'($urandom_range(floor_top + 32768)));
            BAND_MID:
                if (lo_sel < hi_sel)
                begin
                    if (at_border)
                        return $urandom_range(1) ? 16'(hi_sel) : 16'(lo_sel + 1);
                    return 16'(lo_sel + 1 + int'($urandom_range(hi_sel - lo_sel - 1)));
                end
            BAND_HIGH:
                if (hi_sel < 32767)
                    return at_border ? 16'(hi_sel + 1)
                                     : 16'(hi_sel + 1 + int'($urandom_range(32766 - hi_sel)));
            default: ;
        endcase
        return 16'($urandom);
    endfunction

    // Offer one sample and hold it until the transfer; valid stays high after
    task automatic push_sample(input logic signed [15:0] s, input bit last);
        @(negedge clk);
        while (idle_roll())
        begin
            smp_ch.valid <= 1'b0;
            @(negedge clk);
        end
        smp_ch.valid    <= 1'b1;
        smp_ch.sample   <= s;
        smp_ch.end_mark <= last;
        @(posedge clk);
        while (!smp_ch.ready)
            @(posedge clk);
        samples_sent++;
    endtask

    // Drop valid, wait for every predicted result, then let the latency pass
    task automatic settle();
        @(negedge clk);
        smp_ch.valid <= 1'b0;
        while (waiting_results != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.addr  <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        cfg_writes++;
    endtask

    // Load a full setting once the block is idle. Mode bits carry random
    // upper bits, which the block must ignore.
    task automatic apply_setting(input int lo_v, input int hi_v,
                                 input bit inv, input bit q_rise, input bit q_fall);
        logic [CFG_DATA_BITS-1:0] pad;
        settle();
        lo_sel = lo_v;
        hi_sel = hi_v;
        write_reg(CFG_LOW_THR, 16'(lo_v));
        write_reg(CFG_HIGH_THR, 16'(hi_v));
        pad = 16'($urandom);
        pad[0] = inv;
        write_reg(CFG_INVERT, pad);
        pad = 16'($urandom);
        pad[0] = q_rise;
        write_reg(CFG_QUICK_RISE, pad);
        pad = 16'($urandom);
        pad[0] = q_fall;
        write_reg(CFG_QUICK_FALL, pad);
        // indexes past the map must leave every register alone
        if ($urandom_range(1))
            write_reg(CFG_ADDR_BITS'(int'(CFG_QUICK_FALL) + 1 + int'($urandom_range(2))),
                      16'($urandom));
        settings_used++;
    endtask

    // Mostly middle runs closed by a low or high sample, some closed by an
    // end mark inside the run, and a tenth raw noise
    task automatic run_phase(input int items);
        int sent;
        int run_len;
        int k;
        bit close_in_run;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(99) < 10)
            begin
                push_sample(16'($urandom), $urandom_range(99) < 5);
                sent++;
            end
            else
            begin
                run_len      = $urandom_range(6);
                close_in_run = (run_len != 0) && ($urandom_range(99) < 5);
                for (k = 0; k < run_len; k++)
                    push_sample(pick_sample(BAND_MID), close_in_run && (k == run_len - 1));
                sent += run_len;
                if (!close_in_run)
                begin
                    push_sample(pick_sample($urandom_range(1) ? BAND_HIGH : BAND_LOW),
                                $urandom_range(99) < 8);
                    sent++;
                end
            end
        end
    endtask

    // Sink side: stall at random, except during a calm stretch
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= !idle_roll();
        end
    end

    // Watchdog: end the run when no channel has moved for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp_ch.valid && smp_ch.ready) || (res_ch.valid && res_ch.ready) ||
                (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
            begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT)
                begin
                    $display("timeout: %0d cycles without a transfer", QUIET_LIMIT);
                    $display("FAILED: results differ");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        // Hold every input at a known value from time zero
        rst_n           = 1'b0;
        calm            = 1'b0;
        smp_ch.valid    = 1'b0;
        smp_ch.sample   = '0;
        smp_ch.end_mark = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.addr     = '0;
        cfg_ch.data     = '0;
        lo_sel          = 0;
        hi_sel          = 1;
        samples_sent    = 0;
        cfg_writes      = 0;
        settings_used   = 0;
        quiet_cycles    = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // Reset thresholds: only 1 is middle. A leading run counts as coming
        // from the low band, so it decides inactive when it exits high.
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd2, 1'b0);

        apply_setting(-100, 100, 1'b0, 1'b0, 1'b0);
        // band edges and full-scale extremes
        push_sample(-16'sd32768, 1'b0);
        push_sample(16'sd32767, 1'b0);
        push_sample(-16'sd100, 1'b0);      // equal to low threshold: low
        push_sample(-16'sd99, 1'b0);       // just above low: middle
        push_sample(16'sd100, 1'b0);       // equal to high threshold: middle
        push_sample(16'sd101, 1'b0);       // run from low exits high
        push_sample(16'sd0, 1'b0);
        push_sample(-16'sd32768, 1'b1);    // run from high exits low, closes signal
        push_sample(16'sd50, 1'b0);
        push_sample(16'sd50, 1'b1);        // end mark inside a run from low
        push_sample(16'sd200, 1'b0);
        push_sample(16'sd5, 1'b1);         // end mark inside a run from high
        push_sample(16'sd300, 1'b1);       // end mark on a lone high sample

        // Quick modes and inverted output; an end mark inside a run ignores
        // the quick modes
        apply_setting(-100, 100, 1'b1, 1'b1, 1'b1);
        push_sample(-16'sd500, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(16'sd500, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(-16'sd500, 1'b0);
        push_sample(16'sd0, 1'b1);

        // Thresholds out of order: anything above high is high, rest is low
        apply_setting(100, -100, 1'b0, 1'b0, 1'b0);
        push_sample(16'sd0, 1'b0);
        push_sample(-16'sd100, 1'b0);
        push_sample(-16'sd200, 1'b1);

        // Random part over several settings, extremes first
        for (phase = 0; phase < PHASE_COUNT; phase++)
        begin
            case (phase)
                0: apply_setting(-32768, 32767, 1'b0, 1'b0, 1'b0);
                1: apply_setting(32767, -32768, 1'b1, 1'b1, 1'b1);
                2:
                begin
                    lo = int'($urandom_range(65535)) - 32768;
                    apply_setting(lo, lo, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                end
                3:
                begin
                    lo = int'($signed(16'($urandom)));
                    hi = int'($signed(16'($urandom)));
                    apply_setting(lo, hi, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                end
                default:
                begin
                    lo = int'($urandom_range(7000)) - 4000;
                    hi = lo + 1 + int'($urandom_range(3000));
                    apply_setting(lo, hi, 1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                end
            endcase
            calm = (phase == 5);
            run_phase(PHASE_ITEMS);
        end
        calm = 1'b0;

        // Drain and give any stray result time to show up
        settle();
        repeat (8) @(negedge clk);

        $display("Ran %0d samples giving %0d results, %0d register writes in %0d settings.",
                 samples_sent, results_checked, cfg_writes, settings_used);
        $display("Covered band edges, quick and inverted modes, swapped thresholds.");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
